// ----- sv/fdtd_1d_time_step_defines.svh -----
// Assertion macros for the FDTD time step block
`ifndef FDTD_1D_TIME_STEP_DEFINES_SVH
`define FDTD_1D_TIME_STEP_DEFINES_SVH

// assertion that is switched off while reset is high
`define FDTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that is also checked during reset
`define FDTD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/fdtd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FDTD 1D package
// Widths, register indexes, reset values and saturation for the time stepper.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  localparam int CELLS_DEF = 256;

  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 17;
  localparam int NODE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_COURANT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABC_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_A  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_B  = 3'd4;

  localparam logic [COEF_W-1:0] COURANT_RST  = 17'd65536;
  localparam logic [COEF_W-1:0] ABC_COEF_RST = 17'd0;
  localparam logic [NODE_W-1:0] SOURCE_RST   = 8'd19;
  localparam logic [NODE_W-1:0] PROBE_A_RST  = 8'd80;
  localparam logic [NODE_W-1:0] PROBE_B_RST  = 8'd130;

  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [FIELD_W-1:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[FIELD_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/fdtd_1d_time_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FDTD 1D time step
// Each input word advances a Yee grid with a TFSF source by one step and
// returns the E field at two probe nodes.
// ----------------------------------------------------------------------------
// For each step, the H pass and the E pass each stream all CELLS nodes
// through the E and H memories, one read-modify-write per cycle in a
// four-stage pipeline that drains between the passes, and the right
// absorbing boundary and left copy run after. After reset a clearing pass
// zeroes both memories before the first input is taken. Registers may be
// written at any time the block is idle.
module fdtd_1d_time_step #(
  parameter int CELLS = fdtd_pkg::CELLS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  signed [fdtd_pkg::FIELD_W-1:0]     src_h_sample,
  input  wire  signed [fdtd_pkg::FIELD_W-1:0]     src_e_sample,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [fdtd_pkg::FIELD_W-1:0]     probe_a_value,
  output logic signed [fdtd_pkg::FIELD_W-1:0]     probe_b_value,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire         [fdtd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire         [fdtd_pkg::CFG_DW-1:0]      cfg_data
);
  import fdtd_pkg::*;

  localparam int AW = $clog2(CELLS);
  localparam int CW = ((AW > NODE_W) ? AW : NODE_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] PENULT = AW'(CELLS - 2);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PREP, S_HPASS, S_HDRAIN, S_EPASS, S_EDRAIN,
    S_ABC1, S_ABC2, S_ABC3, S_WB, S_W0, S_FIN
  } state_t;

  state_t state;
  logic [AW-1:0] k;
  logic hmode;

  logic [COEF_W-1:0] courant;
  logic signed [COEF_W-1:0] abc_coef;
  logic [NODE_W-1:0] source_node, probe_a_node, probe_b_node;

  logic signed [FIELD_W-1:0] hs, es, rpe, e1, elast, enm2, pa, pb, at;
  logic signed [34:0] hneg, esc;
  logic signed [32:0] ad;
  logic signed [49:0] ap;

  logic signed [FIELD_W-1:0] e_mem [CELLS];
  logic signed [FIELD_W-1:0] h_mem [CELLS-1];
  logic signed [FIELD_W-1:0] e_rd, h_rd;
  logic [AW-1:0] h_raddr, e_waddr, h_waddr;
  logic signed [FIELD_W-1:0] e_wdata, h_wdata;
  logic e_we, h_we;

  logic v1, v2, v3, v4;
  logic [AW-1:0] k1, m2, m3, m4;
  logic signed [FIELD_W-1:0] a_prev, b2, b3, s4, wval;
  logic signed [32:0] d2;
  logic signed [50:0] p3;
  logic signed [FIELD_W-1:0] a_cur, base;
  logic [AW-1:0] m1;
  logic use1, issue, src_ok, corr4, wb_corr;
  logic signed [17:0] cs;
  logic signed [49:0] hprod, eprod;
  logic signed [FIELD_W-1:0] wb_val;

  assign cs = $signed({1'b0, courant});
  assign src_ok = CW'(source_node) < CW'(CELLS - 1);
  assign issue = (state == S_HPASS) || (state == S_EPASS);
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign hprod = hs * cs;
  assign eprod = es * cs;

  always_comb begin
    if (hmode) h_raddr = (k == '0) ? '0 : k - AW'(1);
    else h_raddr = (k == LAST) ? '0 : k;
  end

  always_ff @(posedge clk) begin
    if (e_we) e_mem[e_waddr] <= e_wdata;
    if (h_we) h_mem[h_waddr] <= h_wdata;
    e_rd <= e_mem[k];
    h_rd <= h_mem[h_raddr];
  end

  // pipeline: stage 1 sees read data, stage 4 writes back
  always_comb begin
    a_cur = hmode ? e_rd : h_rd;
    base  = hmode ? h_rd : e_rd;
    m1    = hmode ? k1 - AW'(1) : k1;
    use1  = hmode ? (k1 != '0) : (k1 != '0 && k1 != LAST);
    if (hmode) corr4 = src_ok && (CW'(m4) == CW'(source_node));
    else corr4 = src_ok && (CW'(m4) == CW'(source_node) + CW'(1));
    wval = corr4 ? sat32(36'(s4) + 36'(hmode ? hneg : esc)) : s4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1 && use1;
      v3 <= v2;
      v4 <= v3;
    end
    k1 <= k;
    if (v1) a_prev <= a_cur;
    d2 <= 33'(a_cur) - 33'(a_prev);
    b2 <= base;
    m2 <= m1;
    p3 <= d2 * cs;
    b3 <= b2;
    m3 <= m2;
    s4 <= sat32(36'(b3) + 36'(p3 >>> 16));
    m4 <= m3;
  end

  always_comb begin
    wb_corr = src_ok && (CW'(source_node) + CW'(1) == CW'(LAST));
    wb_val = wb_corr ? sat32(36'(at) + 36'(esc)) : at;
    e_we = 1'b0;
    h_we = 1'b0;
    e_waddr = m4;
    h_waddr = m4;
    e_wdata = wval;
    h_wdata = wval;
    case (state)
      S_CLR: begin
        e_we = 1'b1;
        h_we = (k != LAST);
        e_waddr = k;
        h_waddr = k;
        e_wdata = '0;
        h_wdata = '0;
      end
      S_WB: begin
        e_we = 1'b1;
        e_waddr = LAST;
        e_wdata = wb_val;
      end
      S_W0: begin
        e_we = 1'b1;
        e_waddr = '0;
        e_wdata = e1;
      end
      default: begin
        e_we = v4 && !hmode;
        h_we = v4 && hmode;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      k <= '0;
      hmode <= 1'b1;
      out_valid <= 1'b0;
      rpe <= '0;
      courant <= COURANT_RST;
      abc_coef <= ABC_COEF_RST;
      source_node <= SOURCE_RST;
      probe_a_node <= PROBE_A_RST;
      probe_b_node <= PROBE_B_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COURANT:  courant <= cfg_data;
          CFG_ABC_COEF: abc_coef <= $signed(cfg_data);
          CFG_SOURCE:   source_node <= cfg_data[NODE_W-1:0];
          CFG_PROBE_A:  probe_a_node <= cfg_data[NODE_W-1:0];
          CFG_PROBE_B:  probe_b_node <= cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end
      if (out_ready && state != S_FIN) out_valid <= 1'b0;
      if (v1 && !hmode && k1 == AW'(1)) e1 <= e_rd;
      if (v1 && !hmode && k1 == LAST) elast <= e_rd;
      if (v4 && !hmode) begin
        if (m4 == PENULT) enm2 <= s4;
        if (CW'(m4) == CW'(probe_a_node)) pa <= wval;
        if (CW'(m4) == CW'(probe_b_node)) pb <= wval;
      end
      case (state)
        S_CLR: begin
          if (k == LAST) begin
            k <= '0;
            state <= S_IDLE;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            hs <= src_h_sample;
            es <= src_e_sample;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          hneg <= -35'(hprod >>> 16);
          esc <= 35'(eprod >>> 16);
          pa <= '0;
          pb <= '0;
          hmode <= 1'b1;
          k <= '0;
          state <= S_HPASS;
        end
        S_HPASS: begin
          k <= k + AW'(1);
          if (k == LAST) state <= S_HDRAIN;
        end
        S_HDRAIN: begin
          if (!(v1 || v2 || v3 || v4)) begin
            hmode <= 1'b0;
            k <= '0;
            state <= S_EPASS;
          end
        end
        S_EPASS: begin
          k <= k + AW'(1);
          if (k == LAST) state <= S_EDRAIN;
        end
        S_EDRAIN: begin
          if (!(v1 || v2 || v3 || v4)) state <= S_ABC1;
        end
        S_ABC1: begin
          ad <= 33'(enm2) - 33'(elast);
          state <= S_ABC2;
        end
        S_ABC2: begin
          ap <= ad * abc_coef;
          state <= S_ABC3;
        end
        S_ABC3: begin
          at <= sat32(36'(rpe) + 36'(ap >>> 16));
          rpe <= enm2;
          state <= S_WB;
        end
        S_WB: begin
          if (CW'(LAST) == CW'(probe_a_node)) pa <= wb_val;
          if (CW'(LAST) == CW'(probe_b_node)) pb <= wb_val;
          state <= S_W0;
        end
        S_W0: begin
          if (probe_a_node == '0) pa <= e1;
          if (probe_b_node == '0) pb <= e1;
          k <= '0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            probe_a_value <= pa;
            probe_b_value <= pb;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/fdtd_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "fdtd_1d_time_step_defines.svh"
// ----------------------------------------------------------------------------
// FDTD 1D checker
// Port-level checks on the time stepper, bound to the top level.
// ----------------------------------------------------------------------------
module fdtd_chk (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 in_valid,
  input wire                                 in_ready,
  input wire                                 out_valid,
  input wire                                 out_ready,
  input wire signed [fdtd_pkg::FIELD_W-1:0]  probe_a_value,
  input wire signed [fdtd_pkg::FIELD_W-1:0]  probe_b_value
);
  `FDTD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(probe_a_value) && $stable(probe_b_value), "result word changed while stalled")
  `FDTD_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready && !$rose(out_valid), "block took a word while stepping")
  `FDTD_ASSERT(a_clear_after_reset, $past(rst) |-> !in_ready && !out_valid, "block live during clearing pass")
endmodule

bind fdtd_1d_time_step fdtd_chk u_chk (.*);
`default_nettype wire
